>>> src/flow_completion_tracker_defines.svh
// Assertion macros for the flow completion tracker
`ifndef FLOW_COMPLETION_TRACKER_DEFINES_SVH
`define FLOW_COMPLETION_TRACKER_DEFINES_SVH
`define FCT_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define FCT_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> src/fct_pkg.sv
// ---------------------------------------------------------------------------
// fct_pkg
// Types and constants of the flow completion tracker.
// ---------------------------------------------------------------------------
`default_nettype none
package fct_pkg;
   localparam int HOP_SLOTS_DEF = 10;
   localparam int SEQ_AT        = 8;
   localparam int COUNT_AT      = 18;
   localparam int STAMP_AT      = 20;

   typedef enum logic [1:0] {
      OUTCOME_COMPLETE = 2'd0,
      OUTCOME_GAP      = 2'd1,
      OUTCOME_PARTIAL  = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT_GAP,
      ST_RESTART,
      ST_CHECK,
      ST_EMIT
   } state_type;

   localparam logic CMD_BYTE   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;
   localparam logic [0:0] CSR_EXPECTED = 1'b0;
   localparam logic [0:0] CSR_FLOWS    = 1'b1;

   // emitter control
   typedef struct packed {
      logic        start;
      outcome_type outcome;
   } emit_ctl_type;
endpackage
`default_nettype wire

>>> src/fct_emit.sv
// ---------------------------------------------------------------------------
// fct_emit
// Walks the hop slots of a record, one result per transfer, through one
// shared subtract-and-compare unit.
// ---------------------------------------------------------------------------
`default_nettype none
module fct_emit #(
   parameter int HOP_SLOTS = fct_pkg::HOP_SLOTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fct_pkg::emit_ctl_type ctl,
   input  wire logic [47:0]          first_stamp,
   input  wire logic [HOP_SLOTS*48-1:0] stamps,
   output logic                      busy,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [3:0]                rsp_hop_index,
   output logic [47:0]               rsp_hop_last_stamp,
   output logic [47:0]               rsp_hop_completion_time,
   output logic [1:0]                rsp_flow_outcome,
   output logic                      rsp_record_last
);
   import fct_pkg::*;
   localparam int HW = (HOP_SLOTS > 1) ? $clog2(HOP_SLOTS) : 1;

   logic          active_ff, active_in;
   logic [HW-1:0] hop_ff, hop_in;
   logic          vld_ff, vld_in;
   logic [3:0]    idx_ff, idx_in;
   logic [47:0]   st_ff, st_in, fct_ff, fct_in;
   logic          last_ff, last_in;
   outcome_type   oc_ff, oc_in;
   logic [47:0]   s;
   logic [48:0]   diff;

   assign s    = stamps[hop_ff*48 +: 48];
   assign diff = {1'b0, s} - {1'b0, first_stamp};

   always_comb begin
      active_in = active_ff;
      hop_in    = hop_ff;
      vld_in    = vld_ff;
      idx_in    = idx_ff;
      st_in     = st_ff;
      fct_in    = fct_ff;
      last_in   = last_ff;
      oc_in     = oc_ff;
      if (vld_ff && rsp_ready) vld_in = 1'b0;
      if (ctl.start) begin
         active_in = 1'b1;
         hop_in    = '0;
         oc_in     = ctl.outcome;
      end else if (active_ff && (!vld_ff || rsp_ready)) begin
         vld_in  = 1'b1;
         idx_in  = 4'(hop_ff);
         st_in   = s;
         fct_in  = (first_stamp != '0 && s != '0 && !diff[48]) ? diff[47:0] : '0;
         last_in = (32'(hop_ff) == HOP_SLOTS - 1);
         if (32'(hop_ff) == HOP_SLOTS - 1) active_in = 1'b0;
         else hop_in = hop_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         vld_ff    <= 1'b0;
         hop_ff    <= '0;
         oc_ff     <= OUTCOME_COMPLETE;
      end else begin
         active_ff <= active_in;
         vld_ff    <= vld_in;
         hop_ff    <= hop_in;
         oc_ff     <= oc_in;
      end
      idx_ff  <= idx_in;
      st_ff   <= st_in;
      fct_ff  <= fct_in;
      last_ff <= last_in;
   end

   assign busy                    = active_ff || vld_ff;
   assign rsp_valid               = vld_ff;
   assign rsp_hop_index           = idx_ff;
   assign rsp_hop_last_stamp      = st_ff;
   assign rsp_hop_completion_time = fct_ff;
   assign rsp_flow_outcome        = oc_ff;
   assign rsp_record_last         = last_ff;

`include "flow_completion_tracker_defines.svh"
   `FCT_ASSERT_IMP(a_last_has_top, clock, reset, vld_ff && last_ff, 32'(idx_ff) == HOP_SLOTS - 1, "last flag off top hop")
   `FCT_ASSERT_NXT(a_hold, clock, reset, vld_ff && !rsp_ready, vld_ff && $stable(idx_ff), "result dropped while stalled")
   `FCT_ASSERT_IMP(a_no_restart, clock, reset, ctl.start, !busy, "record start while busy")
endmodule
`default_nettype wire

>>> src/flow_completion_tracker.sv
// ---------------------------------------------------------------------------
// flow_completion_tracker
// Parses packet headers, checks sequence continuity and emits per-hop flow
// records.
// ---------------------------------------------------------------------------
// Usage:
//  req_ carries one packet byte or a finish command per transfer. Only the
//  first 28+6*HOP_SLOTS header bytes are kept; short packets are dropped.
//  A non-final byte leaves the block idle, ready for the next byte. The
//  final byte is evaluated in ST_EVAL and then ST_CHECK (with ST_EMIT_GAP
//  and ST_RESTART between on a gap); records stream out on rsp_ as
//  HOP_SLOTS transfers, one per cycle while rsp_ready is high, through a
//  single subtract/compare unit; a gap packet that also completes the new
//  flow gives two records. req_ready is low while a record is pending.
//  rsp_ holds a result stable when the receiver stalls, and the walk pauses.
//  csr_ writes take effect the next cycle; write only while idle.
//  Reset (synchronous) clears all flow state; registers return to 1.
//  Once flows_to_receive records are sent or a finish arrives, input is
//  consumed and ignored until reset.
// ---------------------------------------------------------------------------
`default_nettype none
module flow_completion_tracker #(
   parameter int HOP_SLOTS = fct_pkg::HOP_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_packet,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_flow_number,
   output logic [31:0]      rsp_packets_received,
   output logic [63:0]      rsp_first_sequence,
   output logic [63:0]      rsp_last_sequence,
   output logic [47:0]      rsp_first_stamp,
   output logic [15:0]      rsp_last_stamp_count,
   output logic [31:0]      rsp_last_hop_mask,
   output logic [3:0]       rsp_hop_index,
   output logic [47:0]      rsp_hop_last_stamp,
   output logic [47:0]      rsp_hop_completion_time,
   output logic [1:0]       rsp_flow_outcome,
   output logic             rsp_record_last
);
   import fct_pkg::*;
   localparam int MASK_AT = STAMP_AT + 6 * HOP_SLOTS;
   localparam int HDR_LEN = MASK_AT + 8;
   localparam int PW      = $clog2(HDR_LEN + 1);

   logic [31:0] exp_ff, flows_ff;
   logic [PW-1:0] pos_ff, pos_in;
   logic [63:0] seqb_ff, seqb_in;
   logic [15:0] cntb_ff, cntb_in;
   logic [31:0] mapb_ff, mapb_in;
   logic [47:0] stb_ff [HOP_SLOTS];
   logic [47:0] stb_in [HOP_SLOTS];
   logic [47:0] lst_ff [HOP_SLOTS];
   logic [31:0] flow_ff, flow_in, seen_ff, seen_in;
   logic [63:0] fseq_ff, fseq_in, lseq_ff, lseq_in;
   logic [47:0] fst_ff, fst_in;
   logic [15:0] lcnt_ff, lcnt_in;
   logic [31:0] lmask_ff, lmask_in;
   logic started_ff, started_in, done_ff, done_in;
   logic take_pkt;
   state_type st_ff, st_in;
   emit_ctl_type ectl;
   logic ebusy;
   logic [HOP_SLOTS*48-1:0] stamps_flat;
   logic stopped, acc;

   assign stopped = done_ff || (flow_ff > flows_ff);
   assign req_ready = (st_ff == ST_IDLE) && !ebusy;
   assign acc = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff   <= 32'd1;
         flows_ff <= 32'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EXPECTED: exp_ff   <= csr_write_data;
            CSR_FLOWS:    flows_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      int slot_off;
      pos_in     = pos_ff;
      seqb_in    = seqb_ff;
      cntb_in    = cntb_ff;
      mapb_in    = mapb_ff;
      stb_in     = stb_ff;
      flow_in    = flow_ff;
      seen_in    = seen_ff;
      fseq_in    = fseq_ff;
      lseq_in    = lseq_ff;
      fst_in     = fst_ff;
      lcnt_in    = lcnt_ff;
      lmask_in   = lmask_ff;
      started_in = started_ff;
      done_in    = done_ff;
      st_in      = st_ff;
      take_pkt   = 1'b0;
      ectl.start   = 1'b0;
      ectl.outcome = OUTCOME_COMPLETE;
      slot_off   = 0;
      unique case (st_ff)
         ST_IDLE: begin
            if (acc && !stopped) begin
               if (req_command == CMD_FINISH) begin
                  if (started_ff) begin
                     ectl.start   = 1'b1;
                     ectl.outcome = OUTCOME_PARTIAL;
                  end
                  started_in = 1'b0;
                  done_in    = 1'b1;
                  pos_in     = '0;
               end else begin
                  if (32'(pos_ff) < HDR_LEN) begin
                     if (32'(pos_ff) >= SEQ_AT && 32'(pos_ff) < SEQ_AT + 8)
                        seqb_in = {seqb_ff[55:0], req_data_byte};
                     else if (32'(pos_ff) >= COUNT_AT && 32'(pos_ff) < COUNT_AT + 2)
                        cntb_in = {cntb_ff[7:0], req_data_byte};
                     else if (32'(pos_ff) >= STAMP_AT && 32'(pos_ff) < MASK_AT) begin
                        for (int h = 0; h < HOP_SLOTS; h++) begin
                           slot_off = 32'(pos_ff) - STAMP_AT - 6 * h;
                           if (slot_off >= 0 && slot_off < 6)
                              stb_in[h] = {stb_ff[h][39:0], req_data_byte};
                        end
                     end else if (32'(pos_ff) >= MASK_AT && 32'(pos_ff) < MASK_AT + 4)
                        mapb_in = {mapb_ff[23:0], req_data_byte};
                     pos_in = pos_ff + 1'b1;
                  end
                  if (req_end_of_packet) begin
                     pos_in = '0;
                     if (32'(pos_ff) + 1 >= HDR_LEN) st_in = ST_EVAL;
                  end
               end
            end
         end
         ST_EVAL: begin
            if (!started_ff) begin
               started_in = 1'b1;
               seen_in    = 32'd1;
               fseq_in    = seqb_ff;
               fst_in     = stb_ff[0];
               take_pkt   = 1'b1;
               st_in      = ST_CHECK;
            end else if (seqb_ff != lseq_ff + 64'd1) begin
               ectl.start   = 1'b1;
               ectl.outcome = OUTCOME_GAP;
               st_in        = ST_EMIT_GAP;
            end else begin
               if (seen_ff != 32'hFFFF_FFFF) seen_in = seen_ff + 32'd1;
               take_pkt = 1'b1;
               st_in    = ST_CHECK;
            end
         end
         ST_EMIT_GAP: begin
            if (!ebusy) begin
               started_in = 1'b0;
               if (flow_ff >= flows_ff) begin
                  done_in = 1'b1;
                  st_in   = ST_IDLE;
               end else begin
                  flow_in = flow_ff + 32'd1;
                  st_in   = ST_RESTART;
               end
            end
         end
         ST_RESTART: begin
            started_in = 1'b1;
            seen_in    = 32'd1;
            fseq_in    = seqb_ff;
            fst_in     = stb_ff[0];
            take_pkt   = 1'b1;
            st_in      = ST_CHECK;
         end
         ST_CHECK: begin
            if (seen_ff >= exp_ff) begin
               ectl.start   = 1'b1;
               ectl.outcome = OUTCOME_COMPLETE;
               st_in        = ST_EMIT;
            end else st_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (!ebusy) begin
               started_in = 1'b0;
               if (flow_ff >= flows_ff) done_in = 1'b1;
               else flow_in = flow_ff + 32'd1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (take_pkt) begin
         lseq_in  = seqb_ff;
         lcnt_in  = cntb_ff;
         lmask_in = mapb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         pos_ff     <= '0;
         seqb_ff    <= '0;
         cntb_ff    <= '0;
         mapb_ff    <= '0;
         flow_ff    <= 32'd1;
         seen_ff    <= '0;
         fseq_ff    <= '0;
         lseq_ff    <= '0;
         fst_ff     <= '0;
         lcnt_ff    <= '0;
         lmask_ff   <= '0;
         started_ff <= 1'b0;
         done_ff    <= 1'b0;
         for (int h = 0; h < HOP_SLOTS; h++) begin
            stb_ff[h] <= '0;
            lst_ff[h] <= '0;
         end
      end else begin
         st_ff      <= st_in;
         pos_ff     <= pos_in;
         seqb_ff    <= seqb_in;
         cntb_ff    <= cntb_in;
         mapb_ff    <= mapb_in;
         stb_ff     <= stb_in;
         flow_ff    <= flow_in;
         seen_ff    <= seen_in;
         fseq_ff    <= fseq_in;
         lseq_ff    <= lseq_in;
         fst_ff     <= fst_in;
         lcnt_ff    <= lcnt_in;
         lmask_ff   <= lmask_in;
         started_ff <= started_in;
         done_ff    <= done_in;
         if (take_pkt) lst_ff <= stb_ff;
      end
   end

   always_comb begin
      for (int h = 0; h < HOP_SLOTS; h++) stamps_flat[h*48 +: 48] = lst_ff[h];
   end

   fct_emit #(.HOP_SLOTS(HOP_SLOTS)) u_emit (
      .clock                   (clock),
      .reset                   (reset),
      .ctl                     (ectl),
      .first_stamp             (fst_ff),
      .stamps                  (stamps_flat),
      .busy                    (ebusy),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_hop_index           (rsp_hop_index),
      .rsp_hop_last_stamp      (rsp_hop_last_stamp),
      .rsp_hop_completion_time (rsp_hop_completion_time),
      .rsp_flow_outcome        (rsp_flow_outcome),
      .rsp_record_last         (rsp_record_last)
   );

   assign rsp_flow_number      = flow_ff;
   assign rsp_packets_received = seen_ff;
   assign rsp_first_sequence   = fseq_ff;
   assign rsp_last_sequence    = lseq_ff;
   assign rsp_first_stamp      = fst_ff;
   assign rsp_last_stamp_count = lcnt_ff;
   assign rsp_last_hop_mask    = lmask_ff;

`include "flow_completion_tracker_defines.svh"
   `FCT_ASSERT_IMP(a_pos_sat, clock, reset, 1'b1, 32'(pos_ff) <= HDR_LEN, "byte position past header")
   `FCT_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, !rsp_valid, "input taken during record")
   `FCT_ASSERT_NXT(a_done_sticky, clock, reset, done_ff, done_ff, "finished run restarted")
endmodule
`default_nettype wire

>>> verif/tb_flow_completion_tracker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_flow_completion_tracker
// Drives packet bytes and finish commands into the flow tracker, predicts
// every per-hop record in a behavioral model and checks each rsp_ transfer
// field by field. Covers directed header corner cases, register settings,
// random traffic under sender/receiver idling, back-pressure and finish.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_flow_completion_tracker;
   import fct_pkg::*;

   localparam int HOPS    = 10;
   localparam int HDR     = 20 + 6 * HOPS + 8;
   localparam int MASK_AT = 20 + 6 * HOPS;
   localparam int LIMIT   = 600000;

   typedef struct {
      logic [31:0] flow_number;
      logic [31:0] packets_received;
      logic [63:0] first_sequence;
      logic [63:0] last_sequence;
      logic [47:0] first_stamp;
      logic [15:0] last_stamp_count;
      logic [31:0] last_hop_mask;
      logic [3:0]  hop_index;
      logic [47:0] hop_last_stamp;
      logic [47:0] hop_completion_time;
      logic [1:0]  flow_outcome;
      logic        record_last;
   } hop_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [0:0]  csr_index = CSR_EXPECTED;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   wire         req_ready;
   logic        req_command = CMD_BYTE;
   logic [7:0]  req_data_byte = '0;
   logic        req_end_of_packet = 1'b0;
   wire         rsp_valid;
   logic        rsp_ready = 1'b0;
   wire [31:0]  rsp_flow_number, rsp_packets_received, rsp_last_hop_mask;
   wire [63:0]  rsp_first_sequence, rsp_last_sequence;
   wire [47:0]  rsp_first_stamp, rsp_hop_last_stamp, rsp_hop_completion_time;
   wire [15:0]  rsp_last_stamp_count;
   wire [3:0]   rsp_hop_index;
   wire [1:0]   rsp_flow_outcome;
   wire         rsp_record_last;

   flow_completion_tracker dut (.*);

   always #1 clock = ~clock;

   // model state
   logic [31:0] cfg_expected, cfg_flows;
   logic [6:0]  pos;
   logic [63:0] seq_buf, first_seq, last_seq;
   logic [15:0] cnt_buf, last_cnt;
   logic [31:0] map_buf, last_mask, flow_ctr, pkts;
   logic [47:0] stamp_buf [HOPS];
   logic [47:0] last_st [HOPS];
   logic [47:0] first_st;
   logic        started, finished;

   hop_result_t hop_expect_q[$];
   int mismatches = 0;
   int results_seen = 0;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int hold_req = 0;
   int hold_left = 0;
   longint cycles = 0;

   function automatic void push_record(input outcome_type oc);
      hop_result_t r;
      for (int h = 0; h < HOPS; h++) begin
         r.flow_number = flow_ctr;
         r.packets_received = pkts;
         r.first_sequence = first_seq;
         r.last_sequence = last_seq;
         r.first_stamp = first_st;
         r.last_stamp_count = last_cnt;
         r.last_hop_mask = last_mask;
         r.hop_index = 4'(h);
         r.hop_last_stamp = last_st[h];
         r.hop_completion_time = (first_st != 0 && last_st[h] != 0 && last_st[h] >= first_st)
                                 ? last_st[h] - first_st : '0;
         r.flow_outcome = oc;
         r.record_last = (h == HOPS - 1);
         hop_expect_q.push_back(r);
      end
   endfunction

   function automatic void latch_packet();
      last_seq = seq_buf;
      last_cnt = cnt_buf;
      last_mask = map_buf;
      for (int h = 0; h < HOPS; h++) last_st[h] = stamp_buf[h];
   endfunction

   function automatic void open_flow();
      started = 1'b1;
      pkts = 1;
      first_seq = seq_buf;
      first_st = stamp_buf[0];
      latch_packet();
   endfunction

   function automatic void close_flow();
      started = 1'b0;
      if (flow_ctr >= cfg_flows) finished = 1'b1;
      else flow_ctr++;
   endfunction

   function automatic void track_transfer(input logic cmd, input logic [7:0] b,
                                          input logic eop);
      int p;
      if (finished || flow_ctr > cfg_flows) return;
      if (cmd == CMD_FINISH) begin
         if (started) push_record(OUTCOME_PARTIAL);
         started = 1'b0;
         finished = 1'b1;
         pos = '0;
         return;
      end
      p = pos;
      if (p < HDR) begin
         if (p >= SEQ_AT && p < SEQ_AT + 8) seq_buf = {seq_buf[55:0], b};
         else if (p >= COUNT_AT && p < COUNT_AT + 2) cnt_buf = {cnt_buf[7:0], b};
         else if (p >= STAMP_AT && p < MASK_AT)
            stamp_buf[(p - STAMP_AT) / 6] = {stamp_buf[(p - STAMP_AT) / 6][39:0], b};
         else if (p >= MASK_AT && p < MASK_AT + 4) map_buf = {map_buf[23:0], b};
         p++;
      end
      pos = 7'(p);
      if (!eop) return;
      pos = '0;
      if (p < HDR) return;
      if (!started) open_flow();
      else if (seq_buf != last_seq + 64'd1) begin
         push_record(OUTCOME_GAP);
         close_flow();
         if (finished) return;
         open_flow();
      end else begin
         if (pkts != 32'hFFFF_FFFF) pkts++;
         latch_packet();
      end
      if (started && pkts >= cfg_expected) begin
         push_record(OUTCOME_COMPLETE);
         close_flow();
      end
   endfunction

   // receiver side
   always @(negedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   function automatic void check_field(input string name, input logic [63:0] exp_v,
                                       input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("flow_completion_tracker test failed");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (hop_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer");
         end else begin
            hop_result_t e;
            e = hop_expect_q.pop_front();
            results_seen++;
            check_field("flow_number", 64'(e.flow_number), 64'(rsp_flow_number));
            check_field("packets_received", 64'(e.packets_received),
                        64'(rsp_packets_received));
            check_field("first_sequence", e.first_sequence, rsp_first_sequence);
            check_field("last_sequence", e.last_sequence, rsp_last_sequence);
            check_field("first_stamp", 64'(e.first_stamp), 64'(rsp_first_stamp));
            check_field("last_stamp_count", 64'(e.last_stamp_count),
                        64'(rsp_last_stamp_count));
            check_field("last_hop_mask", 64'(e.last_hop_mask), 64'(rsp_last_hop_mask));
            check_field("hop_index", 64'(e.hop_index), 64'(rsp_hop_index));
            check_field("hop_last_stamp", 64'(e.hop_last_stamp), 64'(rsp_hop_last_stamp));
            check_field("hop_completion_time", 64'(e.hop_completion_time),
                        64'(rsp_hop_completion_time));
            check_field("flow_outcome", 64'(e.flow_outcome), 64'(rsp_flow_outcome));
            check_field("record_last", 64'(e.record_last), 64'(rsp_record_last));
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic cmd, input logic [7:0] b, input logic eop);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_data_byte = b;
      req_end_of_packet = eop;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_transfer(cmd, b, eop);
      @(negedge clock);
   endtask

   task automatic send_packet(input logic [63:0] seq, input logic [15:0] cnt,
                              input logic [31:0] mask, input logic [47:0] st [HOPS],
                              input int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (i >= SEQ_AT && i < SEQ_AT + 8) b = seq[8 * (SEQ_AT + 7 - i) +: 8];
         else if (i >= COUNT_AT && i < COUNT_AT + 2) b = cnt[8 * (COUNT_AT + 1 - i) +: 8];
         else if (i >= STAMP_AT && i < MASK_AT)
            b = st[(i - STAMP_AT) / 6][8 * (5 - (i - STAMP_AT) % 6) +: 8];
         else if (i >= MASK_AT && i < MASK_AT + 4) b = mask[8 * (MASK_AT + 3 - i) +: 8];
         send_item(CMD_BYTE, b, i == len - 1);
      end
   endtask

   function automatic logic [47:0] rand_stamp(input logic [47:0] base);
      case ($urandom_range(9))
         0: return '0;
         1: return 48'hFFFF_FFFF_FFFF;
         2: return 48'({$urandom, $urandom});
         3: return base - 48'($urandom_range(1, 1000));
         default: return base + 48'($urandom_range(0, 100000));
      endcase
   endfunction

   task automatic send_random_packet(input int len);
      logic [47:0] st [HOPS];
      logic [63:0] seq;
      st[0] = ($urandom_range(7) == 0) ? 48'h0 : 48'({$urandom, $urandom});
      for (int h = 1; h < HOPS; h++) st[h] = rand_stamp(st[0]);
      seq = last_seq + 64'd1;
      if (!started || $urandom_range(99) < 15) seq = {$urandom, $urandom};
      send_packet(seq, 16'($urandom), $urandom, st, len);
   endtask

   function automatic int random_length();
      case ($urandom_range(9))
         0: return $urandom_range(1, HDR - 1);
         1: return $urandom_range(HDR + 1, HDR + 40);
         default: return HDR;
      endcase
   endfunction

   // waits until the block has settled the last transfer before writing
   task automatic write_csr(input logic [0:0] idx, input logic [31:0] val);
      req_valid = 1'b0;
      while (!req_ready) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = val;
      if (idx == CSR_EXPECTED) cfg_expected = val;
      else cfg_flows = val;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (hop_expect_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic test_header_corners();
      logic [47:0] st [HOPS];
      for (int h = 0; h < HOPS; h++) st[h] = '0;
      write_csr(CSR_FLOWS, 32'hFFFF_FFFF);
      write_csr(CSR_EXPECTED, 32'd1);
      send_packet('0, '0, '0, st, HDR);
      for (int h = 0; h < HOPS; h++) st[h] = 48'hFFFF_FFFF_FFFF;
      send_packet('1, '1, '1, st, HDR);
      for (int h = 0; h < HOPS; h++) st[h] = 48'h1000 + 48'(h * 7) - 48'(h == 5 ? 48'h2000 : 0);
      st[3] = '0;
      send_packet(64'h0123_4567_89AB_CDEF, 16'hA55A, 32'h8000_0001, st, HDR);
      send_packet(64'h11, 16'h1, 32'h3FF, st, HDR - 1);
      send_packet(64'h12, 16'h2, 32'h3FF, st, 1);
      send_packet(64'h13, 16'h3, 32'h155, st, HDR + 30);
      drain();
   endtask

   task automatic test_sequence_gaps();
      logic [47:0] st [HOPS];
      for (int h = 0; h < HOPS; h++) st[h] = 48'h5000 + 48'(h);
      write_csr(CSR_EXPECTED, 32'd3);
      send_packet('1, 16'h10, 32'hF, st, HDR);
      send_packet('0, 16'h11, 32'hF, st, HDR);
      send_packet(64'h40, 16'h12, 32'hF, st, HDR);
      send_packet(64'h41, 16'h13, 32'hF, st, HDR);
      drain();
      write_csr(CSR_EXPECTED, 32'd0);
      send_packet(64'h100, 16'h20, 32'h1, st, HDR);
      write_csr(CSR_EXPECTED, 32'd2);
      send_packet(64'h200, 16'h21, 32'h2, st, HDR);
      drain();
      write_csr(CSR_EXPECTED, 32'd1);
      send_packet(64'h300, 16'h22, 32'h3, st, HDR);
      drain();
      write_csr(CSR_EXPECTED, 32'd2);
      send_packet(64'h400, 16'h23, 32'h4, st, HDR);
      write_csr(CSR_EXPECTED, 32'd1);
      send_packet(64'h900, 16'h24, 32'h5, st, HDR);
      drain();
   endtask

   task automatic test_stopped_run();
      write_csr(CSR_FLOWS, 32'd0);
      for (int i = 0; i < 6; i++) send_item(CMD_BYTE, 8'($urandom), i == 5);
      send_item(CMD_FINISH, 8'hFF, 1'b1);
      drain();
      write_csr(CSR_FLOWS, 32'd1);
      send_random_packet(HDR);
      drain();
      write_csr(CSR_FLOWS, 32'hFFFF_FFFF);
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct);
      int start_results;
      tx_idle_pct = tx_pct;
      rx_stall_pct = rx_pct;
      write_csr(CSR_EXPECTED, 32'($urandom_range(1, 3)));
      start_results = results_seen;
      while (results_seen + hop_expect_q.size() - start_results < 60) begin
         if ($urandom_range(19) == 0)
            send_item(CMD_BYTE, 8'($urandom), 1'($urandom_range(1)));
         else
            send_random_packet(random_length());
      end
      drain();
   endtask

   task automatic test_back_pressure();
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      write_csr(CSR_EXPECTED, 32'd1);
      hold_req = 400;
      repeat (3) send_random_packet(HDR);
      drain();
   endtask

   task automatic test_finish();
      write_csr(CSR_EXPECTED, 32'hFFFF_FFFF);
      send_random_packet(HDR);
      send_random_packet(HDR);
      send_random_packet(40);
      send_item(CMD_FINISH, 8'h5A, 1'b0);
      send_random_packet(HDR);
      send_item(CMD_FINISH, 8'h00, 1'b1);
      drain();
   endtask

   initial begin
      cfg_expected = 1;
      cfg_flows = 1;
      pos = '0;
      seq_buf = '0;
      cnt_buf = '0;
      map_buf = '0;
      flow_ctr = 1;
      pkts = '0;
      first_seq = '0;
      last_seq = '0;
      first_st = '0;
      last_cnt = '0;
      last_mask = '0;
      started = 1'b0;
      finished = 1'b0;
      for (int h = 0; h < HOPS; h++) begin
         stamp_buf[h] = '0;
         last_st[h] = '0;
      end
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_header_corners();
      test_sequence_gaps();
      test_stopped_run();
      test_random_traffic(0, 0);
      test_random_traffic(63, 0);
      test_random_traffic(0, 63);
      test_random_traffic(21, 21);
      test_back_pressure();
      test_finish();
      if (mismatches == 0 && hop_expect_q.size() == 0)
         $display("flow_completion_tracker test passed");
      else
         $display("flow_completion_tracker test failed");
      $finish;
   end
endmodule
`default_nettype wire
